// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the counter set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define ASSERT_IMP(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle implication");

// Checks that the condition holds in the cycle after the trigger.
`define ASSERT_NXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/csmt_pkg.sv -----
// Package with the types and constants of the counter set max tracker.
`default_nettype none

package csmt_pkg;

    localparam int NUM_COUNTERS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 16;
    localparam int POP_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INC = 2'd0,
        FUNC_DEC = 2'd1,
        FUNC_CLR = 2'd2,
        FUNC_QRY = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/counter_set_max_tracker.sv -----
// Counter bank with running maximum and population, built around one scan comparator.
//
//   Channel   Signals                               Direction
//   request   i_valid, o_ready, i_func,              in
//             i_counter_index
//   result    o_valid, i_ready, o_counter_value,     out
//             o_max_count, o_num_at_max
//
// An in-range request goes through ST_READ, ST_MOD, ST_SCAN and ST_LAST to ST_FINISH, which loads
// the output register; the next request is taken only back in ST_IDLE. The steps are one memory
// read, one update write, then one counter read per cycle through the shared compare unit,
// which rebuilds the maximum and its population.
// A request whose index lies beyond the bank goes from ST_IDLE straight to ST_FINISH, loads its
// result there and reports the stored maximum.
// After reset a clearing pass writes zero to every counter; o_ready stays low until it ends.
// The result waits in an output register; a stall there holds the next request in its last
// cycle until the register frees up.
`default_nettype none

`include "assert_macros.svh"

module counter_set_max_tracker #(
    parameter int NUM_COUNTERS = csmt_pkg::NUM_COUNTERS_DEF,
    parameter int COUNT_BITS   = csmt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [csmt_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [csmt_pkg::INDEX_W-1:0]   i_counter_index,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [csmt_pkg::VALUE_W-1:0]        o_counter_value,
    output logic [csmt_pkg::VALUE_W-1:0]        o_max_count,
    output logic [csmt_pkg::POP_W-1:0]          o_num_at_max
);

    localparam int AW = $clog2(NUM_COUNTERS);
    localparam int PW = $clog2(NUM_COUNTERS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_COUNTERS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};

    csmt_pkg::t_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_mem [NUM_COUNTERS];
    logic [COUNT_BITS-1:0] r_rdata;

    csmt_pkg::t_func       r_func;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_addr;
    logic [COUNT_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_smax;
    logic [PW-1:0]         r_spop;
    logic                  r_sv;
    logic [COUNT_BITS-1:0] r_max;
    logic [PW-1:0]         r_pop;

    logic                          r_o_valid;
    logic [csmt_pkg::VALUE_W-1:0]  r_o_value;
    logic [csmt_pkg::VALUE_W-1:0]  r_o_max;
    logic [csmt_pkg::POP_W-1:0]    r_o_pop;

    logic                  accept;
    logic                  in_range;
    logic                  out_free;
    logic                  out_load;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [COUNT_BITS-1:0] new_val;
    logic                  addr_last;

    assign o_ready         = (r_state == csmt_pkg::ST_IDLE);
    assign accept          = i_valid && o_ready;
    assign in_range        = (32'(i_counter_index) < 32'(NUM_COUNTERS));
    assign out_free        = !r_o_valid || i_ready;
    assign addr_last       = (r_addr == LAST_ADDR);
    assign o_valid         = r_o_valid;
    assign o_counter_value = r_o_value;
    assign o_max_count     = r_o_max;
    assign o_num_at_max    = r_o_pop;

    always_comb begin
        case (r_func)
            csmt_pkg::FUNC_INC: new_val = (r_rdata != CNT_TOP) ? r_rdata + 1'b1 : r_rdata;
            csmt_pkg::FUNC_DEC: new_val = (r_rdata != '0) ? r_rdata - 1'b1 : r_rdata;
            csmt_pkg::FUNC_CLR: new_val = '0;
            default:            new_val = r_rdata;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = new_val;
        mem_raddr = r_idx;
        case (r_state)
            csmt_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '0;
                if (addr_last) begin
                    n_state = csmt_pkg::ST_IDLE;
                end
            end
            csmt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = in_range ? csmt_pkg::ST_READ : csmt_pkg::ST_FINISH;
                end
            end
            csmt_pkg::ST_READ: begin
                n_state = csmt_pkg::ST_MOD;
            end
            csmt_pkg::ST_MOD: begin
                mem_we  = 1'b1;
                n_state = csmt_pkg::ST_SCAN;
            end
            csmt_pkg::ST_SCAN: begin
                mem_raddr = r_addr;
                if (addr_last) begin
                    n_state = csmt_pkg::ST_LAST;
                end
            end
            csmt_pkg::ST_LAST: begin
                n_state = csmt_pkg::ST_FINISH;
            end
            csmt_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = csmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= csmt_pkg::ST_CLEAR;
            r_addr    <= '0;
            r_sv      <= 1'b0;
            r_o_valid <= 1'b0;
            r_max     <= '0;
            r_pop     <= PW'(NUM_COUNTERS);
        end else begin
            r_state <= n_state;
            r_sv    <= (r_state == csmt_pkg::ST_SCAN);
            if (out_load) begin
                r_o_valid <= 1'b1;
                r_max     <= r_smax;
                r_pop     <= r_spop;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                csmt_pkg::ST_CLEAR,
                csmt_pkg::ST_SCAN: begin
                    r_addr <= addr_last ? '0 : r_addr + 1'b1;
                end
                csmt_pkg::ST_MOD: begin
                    r_addr <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= csmt_pkg::t_func'(i_func);
            r_idx   <= AW'(i_counter_index);
            r_value <= '0;
            r_smax  <= r_max;
            r_spop  <= r_pop;
        end
        if (r_state == csmt_pkg::ST_MOD) begin
            r_value <= new_val;
            r_smax  <= '0;
            r_spop  <= '0;
        end
        if (r_sv) begin
            if (r_rdata > r_smax) begin
                r_smax <= r_rdata;
                r_spop <= PW'(1);
            end else if (r_rdata == r_smax) begin
                r_spop <= r_spop + 1'b1;
            end
        end
        if (out_load) begin
            r_o_value <= csmt_pkg::VALUE_W'(r_value);
            r_o_max   <= csmt_pkg::VALUE_W'(r_smax);
            r_o_pop   <= csmt_pkg::POP_W'(r_spop);
        end
    end

    // The population of the maximum is never zero and never exceeds the bank size.
    `ASSERT_IMP(a_pop_range, i_clk, i_rst_n, r_state == csmt_pkg::ST_IDLE,
        r_pop != '0 && r_pop <= PW'(NUM_COUNTERS))
    // The last scan read is followed by its compare in ST_LAST, the state after the scan.
    `ASSERT_NXT(a_scan_tail, i_clk, i_rst_n, r_state == csmt_pkg::ST_SCAN && addr_last,
        r_state == csmt_pkg::ST_LAST && r_sv)
    // A loaded result carries the maximum that the block keeps for the next request.
    `ASSERT_NXT(a_max_kept, i_clk, i_rst_n, out_load,
        o_valid && o_max_count == csmt_pkg::VALUE_W'(r_max))

endmodule

`default_nettype wire

// ----- tb/counter_set_max_tracker_test.sv -----
// Self-checking testbench for the counter set max tracker, with a scoreboard that tracks the bank.
`default_nettype none

module counter_set_max_tracker_test;

    typedef struct packed {
        logic [csmt_pkg::VALUE_W-1:0] value;
        logic [csmt_pkg::VALUE_W-1:0] peak;
        logic [csmt_pkg::POP_W-1:0]   peak_pop;
    } t_report;

    class count_bank_scoreboard;
        logic [csmt_pkg::VALUE_W-1:0] counts [csmt_pkg::NUM_COUNTERS_DEF];
        t_report                      expected_reports [$];
        int                           failures;

        function new();
            foreach (counts[k]) counts[k] = '0;
            failures = 0;
        endfunction

        function void note_request(csmt_pkg::t_func f, logic [csmt_pkg::INDEX_W-1:0] idx);
            logic [csmt_pkg::VALUE_W-1:0] c;
            t_report                      r;
            c = counts[idx];
            case (f)
                csmt_pkg::FUNC_INC: begin
                    if (c != '1) c = c + 1'b1;
                end
                csmt_pkg::FUNC_DEC: begin
                    if (c != '0) c = c - 1'b1;
                end
                csmt_pkg::FUNC_CLR: begin
                    c = '0;
                end
                default: begin
                end
            endcase
            counts[idx] = c;
            r.value    = c;
            r.peak     = '0;
            r.peak_pop = '0;
            foreach (counts[k]) begin
                if (counts[k] > r.peak) begin
                    r.peak     = counts[k];
                    r.peak_pop = 5'd1;
                end else if (counts[k] == r.peak) begin
                    r.peak_pop = r.peak_pop + 1'b1;
                end
            end
            expected_reports = {expected_reports, r};
        endfunction

        function void check_result(logic [csmt_pkg::VALUE_W-1:0] value,
                                   logic [csmt_pkg::VALUE_W-1:0] peak,
                                   logic [csmt_pkg::POP_W-1:0] peak_pop);
            t_report r;
            if (expected_reports.size() == 0) begin
                $error("result with no request outstanding: value %0d max %0d pop %0d",
                       value, peak, peak_pop);
                failures++;
                return;
            end
            r = expected_reports.pop_front();
            if (value !== r.value) begin
                $error("counter_value: expected %0d, actual %0d", r.value, value);
                failures++;
            end
            if (peak !== r.peak) begin
                $error("max_count: expected %0d, actual %0d", r.peak, peak);
                failures++;
            end
            if (peak_pop !== r.peak_pop) begin
                $error("num_at_max: expected %0d, actual %0d", r.peak_pop, peak_pop);
                failures++;
            end
        endfunction
    endclass

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_valid         = 1'b0;
    logic                           o_ready;
    csmt_pkg::t_func                i_func          = csmt_pkg::FUNC_QRY;
    logic [csmt_pkg::INDEX_W-1:0]   i_counter_index = '0;
    logic                           o_valid;
    logic                           i_ready         = 1'b0;
    logic [csmt_pkg::VALUE_W-1:0]   o_counter_value;
    logic [csmt_pkg::VALUE_W-1:0]   o_max_count;
    logic [csmt_pkg::POP_W-1:0]     o_num_at_max;

    count_bank_scoreboard sb;
    int                   tx_idle_pct = 20;
    int                   rx_idle_pct = 51;
    bit                   hold_request = 1'b0;
    int                   hold_left = 0;

    counter_set_max_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_counter_index (i_counter_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_counter_value (o_counter_value),
        .o_max_count     (o_max_count),
        .o_num_at_max    (o_num_at_max)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A long hold-off on the result side lets the block fill up and stall requests.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = 300;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_counter_value, o_max_count, o_num_at_max);
        end
    end

    task automatic send_request(input csmt_pkg::t_func f,
                                input logic [csmt_pkg::INDEX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= f;
        i_counter_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(f, idx);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_random(input int n, input int hold_at);
        int                           pick;
        csmt_pkg::t_func              f;
        logic [csmt_pkg::INDEX_W-1:0] idx;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_request = 1'b1;
            pick = $urandom_range(99);
            if (pick < 45) f = csmt_pkg::FUNC_INC;
            else if (pick < 70) f = csmt_pkg::FUNC_DEC;
            else if (pick < 80) f = csmt_pkg::FUNC_CLR;
            else f = csmt_pkg::FUNC_QRY;
            if ($urandom_range(1)) idx = csmt_pkg::INDEX_W'($urandom_range(3));
            else idx = csmt_pkg::INDEX_W'($urandom_range(15));
            send_request(f, idx);
        end
    endtask

    initial begin
        int waited;
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(csmt_pkg::FUNC_QRY, 4'd0);
        send_request(csmt_pkg::FUNC_QRY, 4'd15);
        send_request(csmt_pkg::FUNC_DEC, 4'd3);
        send_request(csmt_pkg::FUNC_CLR, 4'd12);
        send_request(csmt_pkg::FUNC_INC, 4'd0);
        send_request(csmt_pkg::FUNC_INC, 4'd15);
        send_request(csmt_pkg::FUNC_INC, 4'd15);
        send_request(csmt_pkg::FUNC_QRY, 4'd0);
        send_request(csmt_pkg::FUNC_DEC, 4'd15);
        send_request(csmt_pkg::FUNC_DEC, 4'd15);
        send_request(csmt_pkg::FUNC_DEC, 4'd0);
        send_request(csmt_pkg::FUNC_INC, 4'd5);
        send_request(csmt_pkg::FUNC_INC, 4'd10);
        send_request(csmt_pkg::FUNC_INC, 4'd10);
        send_request(csmt_pkg::FUNC_INC, 4'd5);
        send_request(csmt_pkg::FUNC_CLR, 4'd10);
        send_request(csmt_pkg::FUNC_CLR, 4'd5);
        send_request(csmt_pkg::FUNC_INC, 4'd6);
        send_request(csmt_pkg::FUNC_INC, 4'd9);
        send_request(csmt_pkg::FUNC_CLR, 4'd6);
        send_request(csmt_pkg::FUNC_DEC, 4'd9);
        send_request(csmt_pkg::FUNC_QRY, 4'd10);

        // Decrement one counter at zero, which holds it there, then step it up past its neighbors and clear it.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(csmt_pkg::FUNC_DEC, 4'd9);
        send_request(csmt_pkg::FUNC_INC, 4'd9);
        send_request(csmt_pkg::FUNC_INC, 4'd9);
        send_request(csmt_pkg::FUNC_QRY, 4'd9);
        send_request(csmt_pkg::FUNC_INC, 4'd2);
        send_request(csmt_pkg::FUNC_CLR, 4'd9);
        send_request(csmt_pkg::FUNC_QRY, 4'd9);
        wait_for_results();

        tx_idle_pct = 20;
        rx_idle_pct = 51;
        run_random(170, 40);
        wait_for_results();
        tx_idle_pct = 51;
        rx_idle_pct = 20;
        run_random(170, -1);
        wait_for_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(160, 60);
        i_valid <= 1'b0;

        waited = 0;
        while (sb.expected_reports.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.expected_reports.size() != 0) begin
            $error("%0d results never arrived", sb.expected_reports.size());
            sb.failures += sb.expected_reports.size();
        end
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/csmt_pkg.sv
rtl/core/counter_set_max_tracker.sv
tb/counter_set_max_tracker_test.sv
